// ===== src/thkr_pkg.sv =====
`default_nettype none
package thkr_pkg;

    localparam int SLOTS     = 4;
    localparam int SLOT_W    = 2;
    localparam int BUF_DEPTH = 16;
    localparam int BUF_AW    = 4;
    localparam int CNT_W     = 5;
    localparam int EVT_W     = 17;

    // Dual-role keycodes are 0x7E00 .. 0x7E0F: upper 12 bits fixed
    localparam logic [11:0] DUAL_PAGE = 12'h7E0;

    localparam logic [1:0] PH_WAIT = 2'd0;
    localparam logic [1:0] PH_HOLD = 2'd1;
    localparam logic [1:0] PH_REL  = 2'd2;

    localparam logic [1:0] ACT_PASS = 2'd0;
    localparam logic [1:0] ACT_TAP  = 2'd1;
    localparam logic [1:0] ACT_HOLD = 2'd2;
    localparam logic [1:0] ACT_HREL = 2'd3;

    localparam logic [2:0] CFG_W_ELAPSED  = 3'd0;
    localparam logic [2:0] CFG_W_INTERVAL = 3'd1;
    localparam logic [2:0] CFG_BIAS       = 3'd2;
    localparam logic [2:0] CFG_GUARD      = 3'd3;
    localparam logic [2:0] CFG_REL_DELAY  = 3'd4;
    localparam logic [2:0] CFG_ENTRY_CNT  = 3'd5;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  entry;
        logic [15:0] code;
        logic        pressed;
    } result_t;

    typedef struct packed {
        logic        busy;
        logic [1:0]  phase;
        logic [3:0]  entry;
        logic [15:0] start;
        logic [15:0] gap;
        logic        joined;
    } slot_t;

    function automatic logic [15:0] since_ms(input logic [15:0] now, input logic [15:0] past);
        return now - past;
    endfunction

endpackage
`default_nettype wire

// ===== src/tap_hold_key_resolver_unit.sv =====
// Tap/hold resolver for dual-role keys.
// Input stream (s_*): one transfer per key event or scan tick; s_tuser is the
// command (0 key event, 1 tick). Output stream (m_*): zero or more result
// transfers per input, m_tlast marks the final one. An input that is consumed
// silently (buffered event, press of a dual-role key) gives no transfer.
// Config channel (cfg_*): register index and data, always ready; write only
// while the block is idle.
// Sequencing: one item at a time. Dispatch, then a release slot walk (one slot
// per cycle), score (multiply then add), tick walk (check, then next slot) per
// slot plus one replay check per forced hold, replay of buffered events (read
// through the registered buffer RAM, then emit) plus a close-out check, and a
// finish step.
// Results pass through a one-deep pending stage so that last can be set, then
// an output register; a stalled receiver (m_tready low) freezes the sequencer
// at its next result, nothing is dropped. s_tready is high only when idle.
// Reset clears slot state, buffer fill count and config to defaults; the
// buffer RAM itself is not cleared (entries are read only after written).
`default_nettype none
module tap_hold_key_resolver_unit
    import thkr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // s_tdata: key_code[15:0], pressed[16], now_ms[32:17], zero pad
    input  wire logic [39:0] s_tdata,
    // s_tuser: cmd[0]
    input  wire logic        s_tuser,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // m_tdata: entry[3:0], key_code_res[19:4], key_pressed[20], zero pad
    output logic      [23:0] m_tdata,
    // m_tuser: action[1:0]
    output logic      [1:0]  m_tuser,
    output logic             m_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DISPATCH = 4'd1;
    localparam logic [3:0] ST_SEARCH   = 4'd2;
    localparam logic [3:0] ST_MUL      = 4'd3;
    localparam logic [3:0] ST_SCORE    = 4'd4;
    localparam logic [3:0] ST_HREL_TAP = 4'd5;
    localparam logic [3:0] ST_TICK     = 4'd6;
    localparam logic [3:0] ST_TICK_NXT = 4'd7;
    localparam logic [3:0] ST_RPL_RD   = 4'd8;
    localparam logic [3:0] ST_RPL_EMIT = 4'd9;
    localparam logic [3:0] ST_FINISH   = 4'd10;

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

    // config registers
    logic [15:0] cfg_we_reg;
    logic [15:0] cfg_wi_reg;
    logic [31:0] cfg_bias_reg;
    logic [15:0] cfg_guard_reg;
    logic [15:0] cfg_rdly_reg;
    logic [4:0]  cfg_ec_reg;

    logic [3:0]        state_reg, state_next;
    logic [3:0]        ret_reg, ret_next;
    logic [SLOT_W-1:0] slot_i_reg, slot_i_next;
    logic              cmd_reg, cmd_next;
    logic [15:0]       code_reg, code_next;
    logic              pr_reg, pr_next;
    logic [15:0]       now_reg, now_next;
    slot_t             slots_reg [SLOTS];
    slot_t             slots_next [SLOTS];
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [31:0]       prod_x_reg, prod_x_next;
    logic [31:0]       prod_y_reg, prod_y_next;
    logic              pend_valid_reg, pend_valid_next;
    result_t           pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;
    logic              out_last_reg, out_last_next;

    // buffer RAM
    logic              mem_we;
    logic [EVT_W-1:0]  mem_wdata;
    logic [EVT_W-1:0]  mem_rdata;

    thkr_ram #(
        .DEPTH (BUF_DEPTH),
        .AW    (BUF_AW),
        .DW    (EVT_W)
    ) u_buf (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[BUF_AW-1:0]),
        .wdata (mem_wdata),
        .raddr (rd_idx_reg[BUF_AW-1:0]),
        .rdata (mem_rdata)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_reg.action;
    assign m_tlast   = out_last_reg;
    assign m_tdata   = {3'b000, out_reg.pressed, out_reg.code, out_reg.entry};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_we_reg    <= 16'd1710;
            cfg_wi_reg    <= 16'hFEAE;       // -338
            cfg_bias_reg  <= 32'hFFFC_AFC4;  // -217148
            cfg_guard_reg <= 16'd250;
            cfg_rdly_reg  <= 16'd5;
            cfg_ec_reg    <= 5'd3;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_W_ELAPSED:  cfg_we_reg    <= cfg_data[15:0];
                CFG_W_INTERVAL: cfg_wi_reg    <= cfg_data[15:0];
                CFG_BIAS:       cfg_bias_reg  <= cfg_data;
                CFG_GUARD:      cfg_guard_reg <= cfg_data[15:0];
                CFG_REL_DELAY:  cfg_rdly_reg  <= cfg_data[15:0];
                CFG_ENTRY_CNT:  cfg_ec_reg    <= cfg_data[4:0];
                default:        ;
            endcase
        end
    end

    // slot status summaries
    logic any_waiting;
    logic any_active;

    always_comb
    begin
        any_waiting = 1'b0;
        any_active  = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slots_reg[i].busy && slots_reg[i].phase == PH_WAIT)
            begin
                any_waiting = 1'b1;
            end
            if (slots_reg[i].busy && slots_reg[i].phase != PH_REL)
            begin
                any_active = 1'b1;
            end
        end
    end

    slot_t              cur;
    logic [15:0]        x_ms;
    logic [15:0]        y_ms;
    logic signed [32:0] mul_x;
    logic signed [32:0] mul_y;
    logic [31:0]        score;
    logic               is_hold;
    logic               out_free;
    logic               emit_ok;
    logic               emit_v;
    result_t            emit_r;
    logic [3:0]         idx;

    assign cur      = slots_reg[slot_i_reg];
    assign x_ms     = since_ms(now_reg, cur.start);
    assign y_ms     = (cur.gap != 16'd0) ? cur.gap : x_ms;
    assign mul_x    = $signed(cfg_we_reg) * $signed({1'b0, x_ms});
    assign mul_y    = $signed(cfg_wi_reg) * $signed({1'b0, y_ms});
    assign score    = prod_x_reg + prod_y_reg + cfg_bias_reg;
    assign is_hold  = (score != 32'd0) && !score[31];
    assign out_free = !out_valid_reg || m_tready;
    assign emit_ok  = !pend_valid_reg || out_free;
    assign idx      = code_reg[3:0];

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        slot_i_next     = slot_i_reg;
        cmd_next        = cmd_reg;
        code_next       = code_reg;
        pr_next         = pr_reg;
        now_next        = now_reg;
        slots_next      = slots_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        prod_x_next     = prod_x_reg;
        prod_y_next     = prod_y_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_wdata       = {pr_reg, code_reg};
        emit_v          = 1'b0;
        emit_r          = '0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = s_tuser;
                    code_next  = s_tdata[15:0];
                    pr_next    = s_tdata[16];
                    now_next   = s_tdata[32:17];
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                slot_i_next = '0;
                if (cmd_reg)
                begin
                    state_next = ST_TICK;
                end
                else if (code_reg[15:4] == DUAL_PAGE)
                begin
                    if ({1'b0, idx} >= cfg_ec_reg)
                    begin
                        // entry out of range passes through
                        if (emit_ok)
                        begin
                            emit_v     = 1'b1;
                            emit_r     = '{ACT_PASS, 4'd0, code_reg, pr_reg};
                            state_next = ST_FINISH;
                        end
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
                else if (any_active && any_waiting && count_reg < CNT_W'(BUF_DEPTH))
                begin
                    if (pr_reg)
                    begin
                        for (int i = 0; i < SLOTS; i++)
                        begin
                            if (slots_reg[i].busy && slots_reg[i].phase != PH_REL)
                            begin
                                slots_next[i].joined = 1'b1;
                                if (slots_reg[i].phase == PH_WAIT && slots_reg[i].gap == 16'd0)
                                begin
                                    slots_next[i].gap = since_ms(now_reg, slots_reg[i].start);
                                end
                            end
                        end
                    end
                    mem_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = ST_FINISH;
                end
                else if (emit_ok)
                begin
                    if (any_active && pr_reg)
                    begin
                        for (int i = 0; i < SLOTS; i++)
                        begin
                            if (slots_reg[i].busy && slots_reg[i].phase != PH_REL)
                            begin
                                slots_next[i].joined = 1'b1;
                                if (slots_reg[i].phase == PH_WAIT && slots_reg[i].gap == 16'd0)
                                begin
                                    slots_next[i].gap = since_ms(now_reg, slots_reg[i].start);
                                end
                            end
                        end
                    end
                    emit_v     = 1'b1;
                    emit_r     = '{ACT_PASS, 4'd0, code_reg, pr_reg};
                    state_next = ST_FINISH;
                end
            end
            ST_SEARCH:
            begin
                if (pr_reg && !cur.busy)
                begin
                    slots_next[slot_i_reg] = '{1'b1, PH_WAIT, idx, now_reg, 16'd0, 1'b0};
                    state_next             = ST_FINISH;
                end
                else if (!pr_reg && cur.busy && cur.entry == idx)
                begin
                    case (cur.phase)
                        PH_WAIT:
                        begin
                            state_next = ST_MUL;
                        end
                        PH_HOLD:
                        begin
                            if (cur.joined)
                            begin
                                slots_next[slot_i_reg].phase = PH_REL;
                                slots_next[slot_i_reg].start = now_reg;
                                state_next                   = ST_FINISH;
                            end
                            else if (emit_ok)
                            begin
                                emit_v     = 1'b1;
                                emit_r     = '{ACT_HREL, cur.entry, 16'd0, 1'b0};
                                state_next = ST_HREL_TAP;
                            end
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
                else if (slot_i_reg != SLOT_LAST)
                begin
                    slot_i_next = slot_i_reg + 1'b1;
                end
                else if (emit_ok)
                begin
                    emit_v     = 1'b1;
                    emit_r     = '{ACT_PASS, 4'd0, code_reg, pr_reg};
                    state_next = ST_FINISH;
                end
            end
            ST_MUL:
            begin
                prod_x_next = mul_x[31:0];
                prod_y_next = mul_y[31:0];
                state_next  = ST_SCORE;
            end
            ST_SCORE:
            begin
                if (emit_ok)
                begin
                    emit_v = 1'b1;
                    if (is_hold && cur.joined)
                    begin
                        emit_r                       = '{ACT_HOLD, cur.entry, 16'd0, 1'b0};
                        slots_next[slot_i_reg].phase = PH_REL;
                        slots_next[slot_i_reg].start = now_reg;
                    end
                    else
                    begin
                        emit_r                      = '{ACT_TAP, cur.entry, 16'd0, 1'b0};
                        slots_next[slot_i_reg].busy = 1'b0;
                    end
                    rd_idx_next = '0;
                    ret_next    = ST_FINISH;
                    state_next  = ST_RPL_RD;
                end
            end
            ST_HREL_TAP:
            begin
                if (emit_ok)
                begin
                    emit_v                      = 1'b1;
                    emit_r                      = '{ACT_TAP, cur.entry, 16'd0, 1'b0};
                    slots_next[slot_i_reg].busy = 1'b0;
                    state_next                  = ST_FINISH;
                end
            end
            ST_TICK:
            begin
                if (cur.busy && cur.phase == PH_WAIT && x_ms > cfg_guard_reg)
                begin
                    // guard time expired: force hold, then replay
                    if (emit_ok)
                    begin
                        emit_v                       = 1'b1;
                        emit_r                       = '{ACT_HOLD, cur.entry, 16'd0, 1'b0};
                        slots_next[slot_i_reg].phase = PH_HOLD;
                        rd_idx_next                  = '0;
                        ret_next                     = ST_TICK_NXT;
                        state_next                   = ST_RPL_RD;
                    end
                end
                else if (cur.busy && cur.phase == PH_REL && x_ms > cfg_rdly_reg)
                begin
                    if (emit_ok)
                    begin
                        emit_v                      = 1'b1;
                        emit_r                      = '{ACT_HREL, cur.entry, 16'd0, 1'b0};
                        slots_next[slot_i_reg].busy = 1'b0;
                        state_next                  = ST_TICK_NXT;
                    end
                end
                else
                begin
                    state_next = ST_TICK_NXT;
                end
            end
            ST_TICK_NXT:
            begin
                if (slot_i_reg == SLOT_LAST)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    slot_i_next = slot_i_reg + 1'b1;
                    state_next  = ST_TICK;
                end
            end
            ST_RPL_RD:
            begin
                // RAM address is rd_idx; data shows up next cycle
                if (any_waiting)
                begin
                    state_next = ret_reg;
                end
                else if (rd_idx_reg < count_reg)
                begin
                    state_next = ST_RPL_EMIT;
                end
                else
                begin
                    count_next = '0;
                    state_next = ret_reg;
                end
            end
            ST_RPL_EMIT:
            begin
                if (emit_ok)
                begin
                    emit_v      = 1'b1;
                    emit_r      = '{ACT_PASS, 4'd0, mem_rdata[15:0], mem_rdata[16]};
                    rd_idx_next = rd_idx_reg + 1'b1;
                    state_next  = ST_RPL_RD;
                end
            end
            ST_FINISH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = pend_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // new result goes to pending; previous pending moves out (not last)
        if (emit_v)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = pend_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_next       = emit_r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ret_reg        <= ST_FINISH;
            slot_i_reg     <= '0;
            count_reg      <= '0;
            rd_idx_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                slots_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            slot_i_reg     <= slot_i_next;
            count_reg      <= count_next;
            rd_idx_reg     <= rd_idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            slots_reg      <= slots_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        code_reg     <= code_next;
        pr_reg       <= pr_next;
        now_reg      <= now_next;
        prod_x_reg   <= prod_x_next;
        prod_y_reg   <= prod_y_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

endmodule
`default_nettype wire

// ===== src/thkr_ram.sv =====
`default_nettype none
module thkr_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 17
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== src/thkr_checker.sv =====
`default_nettype none
module thkr_checker
    import thkr_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output changed while stalled");

    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second input taken during processing");

    a_pass_entry: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ACT_PASS |-> m_tdata[3:0] == 4'd0)
        else $error("pass result carries an entry");

    a_slot_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ACT_PASS |-> m_tdata[20:4] == 17'd0)
        else $error("entry result carries a keycode");

endmodule

bind tap_hold_key_resolver_unit thkr_checker u_thkr_checker (.*);
`default_nettype wire

// ===== tb/sv/tap_hold_key_resolver_unit_chk.sv =====
`default_nettype none
module tap_hold_key_resolver_unit_chk
    import thkr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [39:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [23:0] m_tdata,
    input  wire logic [1:0]  m_tuser,
    input  wire logic        m_tlast,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output int               errors,
    output int               pending,
    output int               seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]  action;
        logic [3:0]  entry;
        logic [15:0] code;
        logic        pressed;
        logic        last;
    } key_result_t;

    key_result_t resolved_q[$];
    key_result_t step_q[$];

    logic [31:0] w_el, w_iv, bias;
    logic [15:0] guard, rel_dly;
    logic [4:0]  n_entries;

    logic        sl_busy[SLOTS];
    logic [1:0]  sl_phase[SLOTS];
    logic [3:0]  sl_entry[SLOTS];
    logic [15:0] sl_start[SLOTS];
    logic [15:0] sl_gap[SLOTS];
    logic        sl_joined[SLOTS];
    logic [16:0] held[BUF_DEPTH];
    int          held_n;

    assign pending = resolved_q.size();

    function automatic void push_res(logic [1:0] a, logic [3:0] e, logic [15:0] c, logic p);
        key_result_t r;
        r.action = a; r.entry = e; r.code = c; r.pressed = p; r.last = 1'b0;
        step_q.push_back(r);
    endfunction

    function automatic bit slot_waits();
        for (int i = 0; i < SLOTS; i++)
            if (sl_busy[i] && sl_phase[i] == PH_WAIT) return 1;
        return 0;
    endfunction

    function automatic bit slot_active();
        for (int i = 0; i < SLOTS; i++)
            if (sl_busy[i] && sl_phase[i] != PH_REL) return 1;
        return 0;
    endfunction

    function automatic void flush_held();
        if (slot_waits()) return;
        for (int i = 0; i < held_n; i++)
            push_res(ACT_PASS, 4'd0, held[i][15:0], held[i][16]);
        held_n = 0;
    endfunction

    function automatic void resolve_release(int i, logic [15:0] now);
        logic [15:0] x, y;
        logic [31:0] sc;
        if (sl_phase[i] == PH_WAIT) begin
            x  = now - sl_start[i];
            y  = (sl_gap[i] != 16'd0) ? sl_gap[i] : x;
            sc = w_el * {16'd0, x} + w_iv * {16'd0, y} + bias;
            if (sc != 32'd0 && !sc[31] && sl_joined[i]) begin
                sl_phase[i] = PH_HOLD;
                push_res(ACT_HOLD, sl_entry[i], 16'd0, 1'b0);
                flush_held();
                sl_phase[i] = PH_REL;
                sl_start[i] = now;
            end else begin
                // unjoined positive score taps too
                push_res(ACT_TAP, sl_entry[i], 16'd0, 1'b0);
                sl_busy[i] = 1'b0;
                flush_held();
            end
        end else if (sl_phase[i] == PH_HOLD) begin
            if (!sl_joined[i]) begin
                push_res(ACT_HREL, sl_entry[i], 16'd0, 1'b0);
                push_res(ACT_TAP, sl_entry[i], 16'd0, 1'b0);
                sl_busy[i] = 1'b0;
            end else begin
                sl_phase[i] = PH_REL;
                sl_start[i] = now;
            end
        end
    endfunction

    // returns 1 when the event is consumed
    function automatic bit take_key(logic [15:0] code, logic pr, logic [15:0] now);
        logic [4:0] idx;
        if (code[15:4] == DUAL_PAGE) begin
            idx = {1'b0, code[3:0]};
            if (idx >= n_entries) return 0;
            for (int i = 0; i < SLOTS; i++) begin
                if (pr) begin
                    if (!sl_busy[i]) begin
                        sl_busy[i] = 1'b1; sl_phase[i] = PH_WAIT; sl_entry[i] = code[3:0];
                        sl_start[i] = now; sl_gap[i] = 16'd0; sl_joined[i] = 1'b0;
                        return 1;
                    end
                end else if (sl_busy[i] && sl_entry[i] == code[3:0]) begin
                    resolve_release(i, now);
                    return 1;
                end
            end
            return 0;
        end
        if (slot_active()) begin
            if (pr)
                for (int i = 0; i < SLOTS; i++)
                    if (sl_busy[i] && (sl_phase[i] == PH_WAIT || sl_phase[i] == PH_HOLD)) begin
                        sl_joined[i] = 1'b1;
                        if (sl_phase[i] == PH_WAIT && sl_gap[i] == 16'd0)
                            sl_gap[i] = now - sl_start[i];
                    end
            if (slot_waits() && held_n < BUF_DEPTH) begin
                held[held_n] = {pr, code};
                held_n++;
                return 1;
            end
        end
        return 0;
    endfunction

    task automatic scan_tick(logic [15:0] now);
        for (int i = 0; i < SLOTS; i++) begin
            if (!sl_busy[i]) continue;
            if (sl_phase[i] == PH_WAIT) begin
                if (16'(now - sl_start[i]) > guard) begin
                    sl_phase[i] = PH_HOLD;
                    push_res(ACT_HOLD, sl_entry[i], 16'd0, 1'b0);
                    flush_held();
                end
            end else if (sl_phase[i] == PH_REL) begin
                if (16'(now - sl_start[i]) > rel_dly) begin
                    push_res(ACT_HREL, sl_entry[i], 16'd0, 1'b0);
                    sl_busy[i] = 1'b0;
                end
            end
        end
    endtask

    task automatic predict_item(logic cmd, logic [15:0] code, logic pr, logic [15:0] now);
        step_q.delete();
        if (cmd) scan_tick(now);
        else if (!take_key(code, pr, now)) push_res(ACT_PASS, 4'd0, code, pr);
        if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
        foreach (step_q[k]) resolved_q.push_back(step_q[k]);
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        key_result_t e;
        if (!rst_n) begin
            w_el = 32'd1710; w_iv = -32'sd338; bias = -32'sd217148;
            guard = 16'd250; rel_dly = 16'd5; n_entries = 5'd3;
            for (int i = 0; i < SLOTS; i++) begin
                sl_busy[i] = 0; sl_phase[i] = PH_WAIT; sl_entry[i] = 0;
                sl_start[i] = 0; sl_gap[i] = 0; sl_joined[i] = 0;
            end
            held_n = 0;
            resolved_q.delete();
            errors = 0;
            seen = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen++;
                if (resolved_q.size() == 0) begin
                    $error("unexpected result transfer: action %0d", m_tuser);
                    errors++;
                end else begin
                    e = resolved_q.pop_front();
                    check_field("action", 32'(e.action), 32'(m_tuser));
                    check_field("entry", 32'(e.entry), 32'(m_tdata[3:0]));
                    check_field("key_code_res", 32'(e.code), 32'(m_tdata[19:4]));
                    check_field("key_pressed", 32'(e.pressed), 32'(m_tdata[20]));
                    check_field("last", 32'(e.last), 32'(m_tlast));
                end
            end
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    CFG_W_ELAPSED:  w_el = {{16{cfg_data[15]}}, cfg_data[15:0]};
                    CFG_W_INTERVAL: w_iv = {{16{cfg_data[15]}}, cfg_data[15:0]};
                    CFG_BIAS:       bias = cfg_data;
                    CFG_GUARD:      guard = cfg_data[15:0];
                    CFG_REL_DELAY:  rel_dly = cfg_data[15:0];
                    CFG_ENTRY_CNT:  n_entries = cfg_data[4:0];
                    default: ;
                endcase
            if (s_tvalid && s_tready)
                predict_item(s_tuser, s_tdata[15:0], s_tdata[16], s_tdata[32:17]);
        end
    end
endmodule
`default_nettype wire

// ===== tb/sv/tap_hold_key_resolver_unit_tb.sv =====
`default_nettype none
module tap_hold_key_resolver_unit_tb
    import thkr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 60;    // margin for the longest item plus output stages
    localparam int RAND_ITEMS  = 270;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic [39:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    int errors, pending, seen;
    int cycles = 0;
    int items = 0;
    int ticks = 0;
    int phases = 0;
    bit calm = 0;           // no idling on either side in the last part
    int stall_left = 0;
    logic [15:0] now_ms = 16'd100;

    // handshake seen at the last rising edge, read by the drivers at the falling edge
    logic s_took = 1'b0, cfg_took = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    tap_hold_key_resolver_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast), .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    tap_hold_key_resolver_unit_chk u_chk (
        .clk(clk), .rst_n(rst_n),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast), .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .errors(errors), .pending(pending), .seen(seen)
    );

    always @(posedge clk) begin
        s_took   <= s_tvalid && s_tready;
        cfg_took <= cfg_valid && cfg_ready;
        cycles   <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("** tap_hold_key_resolver_unit: FAILED **");
            $finish;
        end
    end

    // receiver: random stall bursts, none once calm is set
    always @(negedge clk) begin
        if (stall_left > 0) stall_left--;
        else if (!calm && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 9);
        m_tready <= rst_n && (stall_left == 0);
    end

    // one input transfer; called and returning at a falling edge
    task automatic send_item(logic cmd, logic [15:0] code, logic pr, logic [15:0] now);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'd0, now, pr, code};
        do @(negedge clk); while (!s_took);
        items++;
        if (cmd) ticks++;
    endtask

    task automatic key(logic [15:0] code, logic pr);
        send_item(1'b0, code, pr, now_ms);
    endtask

    task automatic tick_at(int dt);
        now_ms += 16'(dt);
        send_item(1'b1, 16'($urandom), 1'($urandom_range(0, 1)), now_ms);
    endtask

    // drains the block; the sender holds off until every result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge clk); while (!cfg_took);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_regs(logic [15:0] we, logic [15:0] wi, logic [31:0] b,
                             logic [15:0] g, logic [15:0] rd, logic [4:0] ec);
        drain();
        cfg_write(CFG_W_ELAPSED, {16'd0, we});
        cfg_write(CFG_W_INTERVAL, {16'd0, wi});
        cfg_write(CFG_BIAS, b);
        cfg_write(CFG_GUARD, {16'd0, g});
        cfg_write(CFG_REL_DELAY, {16'd0, rd});
        cfg_write(CFG_ENTRY_CNT, {27'd0, ec});
        phases++;
    endtask

    // random non-dual keycode, now and then a dual-role one
    function automatic logic [15:0] any_code();
        if ($urandom_range(0, 7) == 0) return {DUAL_PAGE, 4'($urandom)};
        return 16'($urandom);
    endfunction

    // mostly well-formed dual-role sequences, some noise
    task automatic random_burst();
        int n_dual, n_other;
        logic [3:0] ent[5];
        if ($urandom_range(0, 99) < 8) begin
            now_ms = 16'($urandom);
            send_item(1'($urandom_range(0, 1)), 16'($urandom), 1'($urandom_range(0, 1)),
                      now_ms);
            return;
        end
        n_dual  = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 5) : 1;
        n_other = ($urandom_range(0, 6) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 4);
        for (int d = 0; d < n_dual; d++) begin
            ent[d] = ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
            now_ms += 16'($urandom_range(0, 20));
            key({DUAL_PAGE, ent[d]}, 1'b1);
        end
        for (int k = 0; k < n_other; k++) begin
            if ($urandom_range(0, 3) == 0) tick_at($urandom_range(0, 150));
            else begin
                now_ms += 16'($urandom_range(0, 60));
                key(any_code(), 1'($urandom_range(0, 1)));
            end
        end
        for (int d = 0; d < n_dual; d++)
            if ($urandom_range(0, 9) != 0) begin
                now_ms += 16'($urandom_range(0, 200));
                key({DUAL_PAGE, ent[d]}, 1'b0);
            end
        repeat ($urandom_range(0, 3)) tick_at($urandom_range(0, 40));
    endtask

    initial begin
        int quota;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values, written back explicitly
        load_regs(16'd1710, -16'sd338, -32'sd217148, 16'd250, 16'd5, 5'd3);

        // directed part
        key(16'h0004, 1'b1);                  // plain key, no slot open
        key(16'h0004, 1'b0);
        key({DUAL_PAGE, 4'h0}, 1'b1);         // quick tap
        now_ms += 16'd10; key({DUAL_PAGE, 4'h0}, 1'b0);
        key({DUAL_PAGE, 4'h1}, 1'b1);         // joined, forced to hold by tick
        now_ms += 16'd30; key(16'h0005, 1'b1);
        now_ms += 16'd20; key(16'h0005, 1'b0);
        tick_at(300);                         // hold + replay of both events
        key({DUAL_PAGE, 4'h1}, 1'b0);         // joined hold goes to releasing
        key({DUAL_PAGE, 4'h1}, 1'b0);         // release while releasing: consumed
        tick_at(10);                          // hold release after delay
        key({DUAL_PAGE, 4'h3}, 1'b1);         // entry out of range
        key({DUAL_PAGE, 4'hF}, 1'b0);
        key(16'hFFFF, 1'b1);
        key(16'h0000, 1'b0);
        key({DUAL_PAGE, 4'h2}, 1'b0);         // release with no open slot
        send_item(1'b1, 16'hFFFF, 1'b1, now_ms);
        key({DUAL_PAGE, 4'h2}, 1'b1);         // unjoined hold then release
        tick_at(300);
        key({DUAL_PAGE, 4'h2}, 1'b0);
        key({DUAL_PAGE, 4'h0}, 1'b1);         // positive score but never joined
        now_ms += 16'd200; key({DUAL_PAGE, 4'h0}, 1'b0);
        key({DUAL_PAGE, 4'h0}, 1'b1);         // other press at the same ms: zero interval
        key(16'h0010, 1'b1);
        now_ms += 16'd5; key({DUAL_PAGE, 4'h0}, 1'b0);

        // random phases over several register settings
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: ;
                1: load_regs(16'h8000, 16'h7FFF, 32'h8000_0000, 16'd0, 16'd0, 5'd16);
                2: load_regs(16'h7FFF, 16'h8000, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 5'd0);
                3: load_regs(16'h0A00, 16'hFE00, 32'hFFF0_0000, 16'd120, 16'd3, 5'd16);
                default: load_regs(16'($urandom), 16'($urandom), $urandom,
                                   16'($urandom_range(0, 300)), 16'($urandom_range(0, 20)),
                                   5'($urandom_range(0, 16)));
            endcase
            quota = items + RAND_ITEMS / 5;
            while (items < quota) begin
                if (ph == 4 && quota - items < 30) calm = 1;
                random_burst();
            end
        end

        drain();
        $display("ran %0d input transfers (%0d ticks) over %0d register settings,", items,
                 ticks, phases);
        $display("checked %0d result transfers, %0d mismatches", seen, errors);
        if (errors == 0 && pending == 0)
            $display("** tap_hold_key_resolver_unit: PASSED **");
        else
            $display("** tap_hold_key_resolver_unit: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
src/thkr_pkg.sv
src/thkr_ram.sv
src/tap_hold_key_resolver_unit.sv
src/thkr_checker.sv
tb/sv/tap_hold_key_resolver_unit_chk.sv
tb/sv/tap_hold_key_resolver_unit_tb.sv
